// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/rcfd_pkg.sv -----
// shared constants, types and the strength table of the serial frame decoder
package rcfd_pkg;

	localparam int FRAME_BYTES      = 16;
	localparam int MAX_CHANNELS     = 12;
	localparam int LOW_RES_CHANNELS = 7;

	localparam int BYTE_W    = 8;
	localparam int TIME_W    = 16;
	localparam int CH_W      = 4;
	localparam int PULSE_W   = 11;
	localparam int VALUE_W   = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int ADDR_W   = $clog2(FRAME_BYTES);
	localparam int POS_W    = $clog2(FRAME_BYTES + 1);
	localparam int CH_SEL_W = $clog2(MAX_CHANNELS);
	localparam int COUNT_W  = $clog2(MAX_CHANNELS + 1);

	localparam int LOW_COUNT =
		(LOW_RES_CHANNELS < MAX_CHANNELS) ? LOW_RES_CHANNELS : MAX_CHANNELS;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_RES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_CH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT   = 2'd2;

	localparam logic [TIME_W-1:0]  GAP_LIMIT_RST   = 16'd5000;
	localparam logic [VALUE_W:0]   PULSE_BASE      = 13'd988;
	localparam logic [VALUE_W:0]   PULSE_MAX       = 13'd2047;
	localparam logic [TIME_W-1:0]  FADE_PER_PERIOD = 16'd20;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_issue;
		logic emit_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame_done;
		logic rd_last;
		logic emit_last;
		logic out_free;
	} sts_t;

	// full - floor(delta * full / 20) for delta below 20, full = 2048 or 1024
	function automatic logic [VALUE_W-1:0] strength_value(input logic [4:0] delta,
			input logic high_res);
		logic [VALUE_W-1:0] hi_val;
		logic [VALUE_W-1:0] lo_val;
		case (delta)
			5'd0: begin hi_val = 12'd2048; lo_val = 12'd1024; end
			5'd1: begin hi_val = 12'd1946; lo_val = 12'd973; end
			5'd2: begin hi_val = 12'd1844; lo_val = 12'd922; end
			5'd3: begin hi_val = 12'd1741; lo_val = 12'd871; end
			5'd4: begin hi_val = 12'd1639; lo_val = 12'd820; end
			5'd5: begin hi_val = 12'd1536; lo_val = 12'd768; end
			5'd6: begin hi_val = 12'd1434; lo_val = 12'd717; end
			5'd7: begin hi_val = 12'd1332; lo_val = 12'd666; end
			5'd8: begin hi_val = 12'd1229; lo_val = 12'd615; end
			5'd9: begin hi_val = 12'd1127; lo_val = 12'd564; end
			5'd10: begin hi_val = 12'd1024; lo_val = 12'd512; end
			5'd11: begin hi_val = 12'd922; lo_val = 12'd461; end
			5'd12: begin hi_val = 12'd820; lo_val = 12'd410; end
			5'd13: begin hi_val = 12'd717; lo_val = 12'd359; end
			5'd14: begin hi_val = 12'd615; lo_val = 12'd308; end
			5'd15: begin hi_val = 12'd512; lo_val = 12'd256; end
			5'd16: begin hi_val = 12'd410; lo_val = 12'd205; end
			5'd17: begin hi_val = 12'd308; lo_val = 12'd154; end
			5'd18: begin hi_val = 12'd205; lo_val = 12'd103; end
			5'd19: begin hi_val = 12'd103; lo_val = 12'd52; end
			default: begin hi_val = '0; lo_val = '0; end
		endcase
		return high_res ? hi_val : lo_val;
	endfunction

endpackage

// ----- hw/rtl/rcfd_ram.sv -----
// generic single-write, single-read ram with registered read data
module rcfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/rcfd_ctrl.sv -----
// controller state machine: byte intake, frame read-out and channel report
module rcfd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rcfd_pkg::sts_t sts,
	output rcfd_pkg::cmd_t cmd
);

	import rcfd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd.accept    = 1'b0;
		cmd.rd_issue  = 1'b0;
		cmd.emit_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && sts.frame_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				if (sts.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/rcfd_dp.sv -----
// datapath: config registers, frame store, strength update, decode and output register
module rcfd_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcfd_pkg::CFG_W-1:0]     cfg_data,
	input  logic [rcfd_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [rcfd_pkg::TIME_W-1:0]    gap_us,
	input  logic [rcfd_pkg::TIME_W-1:0]    period_index,
	input  rcfd_pkg::cmd_t                 cmd,
	output rcfd_pkg::sts_t                 sts,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [rcfd_pkg::CH_W-1:0]      channel_index,
	output logic [rcfd_pkg::PULSE_W-1:0]   pulse_value,
	output logic                          last_channel
);

	import rcfd_pkg::*;

	// configuration
	logic              high_res_q;
	logic [CH_W-1:0]   strength_ch_q;
	logic [TIME_W-1:0] gap_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_res_q    <= 1'b1;
			strength_ch_q <= '0;
			gap_limit_q   <= GAP_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HIGH_RES:    high_res_q    <= cfg_data[0];
				REG_STRENGTH_CH: strength_ch_q <= cfg_data[CH_W-1:0];
				REG_GAP_LIMIT:   gap_limit_q   <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// mode-derived values
	logic [CH_W:0] count;
	logic [CH_W-1:0] slot;

	assign count = high_res_q ? (CH_W+1)'(MAX_CHANNELS) : (CH_W+1)'(LOW_COUNT);
	assign slot  = ({1'b0, strength_ch_q} < count) ? strength_ch_q : '0;

	// byte intake
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_eff;
	logic             store_ok;

	assign pos_eff        = (gap_us > gap_limit_q) ? '0 : pos_q;
	assign store_ok       = (pos_eff < POS_W'(FRAME_BYTES));
	assign sts.frame_done = store_ok && (pos_eff == POS_W'(FRAME_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.accept) begin
			pos_q <= store_ok ? pos_eff + POS_W'(1) : pos_eff;
		end
	end

	logic [TIME_W-1:0] period_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.frame_done) begin
			period_q <= period_index;
		end
	end

	// frame store and read-out
	logic [ADDR_W-1:0] rd_addr_q;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic              rd_valid_s1;
	logic [BYTE_W-1:0] rdata;

	rcfd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(FRAME_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (cmd.accept && store_ok),
		.waddr(pos_eff[ADDR_W-1:0]),
		.wdata(rx_byte),
		.re   (cmd.rd_issue),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	assign sts.rd_last = (rd_addr_q == ADDR_W'(FRAME_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_issue;
			if (cmd.accept) begin
				rd_addr_q <= '0;
			end else if (cmd.rd_issue) begin
				rd_addr_q <= rd_addr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_idx_s1 <= rd_addr_q;
		end
	end

	logic fade_hi_stage;
	logic fade_lo_stage;
	logic word_hi_stage;
	logic word_lo_stage;

	assign fade_hi_stage = rd_valid_s1 && (rd_idx_s1 == ADDR_W'(0));
	assign fade_lo_stage = rd_valid_s1 && (rd_idx_s1 == ADDR_W'(1));
	assign word_hi_stage = rd_valid_s1 && (rd_idx_s1 >= ADDR_W'(2)) && !rd_idx_s1[0];
	assign word_lo_stage = rd_valid_s1 && (rd_idx_s1 >= ADDR_W'(3)) && rd_idx_s1[0];

	logic [BYTE_W-1:0] fade_hi_q;
	logic [BYTE_W-1:0] word_hi_q;

	always_ff @(posedge clk) begin
		if (fade_hi_stage) begin
			fade_hi_q <= rdata;
		end
		if (word_hi_stage) begin
			word_hi_q <= rdata;
		end
	end

	// strength from fade count
	logic              fade_seen_q;
	logic [TIME_W-1:0] prior_fade_q;
	logic [TIME_W-1:0] prior_period_q;
	logic [TIME_W-1:0] fade;
	logic [TIME_W-1:0] fade_delta;
	logic [TIME_W-1:0] period_step;
	logic              fade_record;
	logic              strength_wr;
	logic [VALUE_W-1:0] strength_val;

	assign fade         = {fade_hi_q, rdata};
	assign fade_delta   = fade - prior_fade_q;
	assign period_step  = period_q - prior_period_q;
	assign fade_record  = fade_lo_stage && (!fade_seen_q || (prior_period_q != period_q));
	assign strength_wr  = fade_lo_stage && fade_seen_q && (prior_period_q != period_q)
		&& (period_step == TIME_W'(1)) && (slot != '0);
	assign strength_val = (fade_delta >= FADE_PER_PERIOD) ? '0
		: strength_value(fade_delta[4:0], high_res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_seen_q    <= 1'b0;
			prior_fade_q   <= '0;
			prior_period_q <= '0;
		end else if (fade_record) begin
			fade_seen_q    <= 1'b1;
			prior_fade_q   <= fade;
			prior_period_q <= period_q;
		end
	end

	// channel word decode
	logic [CH_W-1:0]    word_ch;
	logic [VALUE_W-1:0] word_value;
	logic               decode_wr;

	assign word_ch    = high_res_q ? word_hi_q[6:3] : word_hi_q[5:2];
	assign word_value = high_res_q ? {1'b0, word_hi_q[2:0], rdata}
		: {2'b00, word_hi_q[1:0], rdata};
	assign decode_wr  = word_lo_stage && ({1'b0, word_ch} < count)
		&& ((slot == '0) || (word_ch != slot));

	logic [VALUE_W-1:0] chan_q [MAX_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				chan_q[i] <= '0;
			end
		end else begin
			if (strength_wr) begin
				chan_q[slot[CH_SEL_W-1:0]] <= strength_val;
			end
			if (decode_wr) begin
				chan_q[word_ch[CH_SEL_W-1:0]] <= word_value;
			end
		end
	end

	// report and output register
	logic [CH_W-1:0]    emit_q;
	logic [VALUE_W-1:0] emit_raw;
	logic [VALUE_W:0]   pulse_sum;
	logic [PULSE_W-1:0] pulse_sat;
	logic               out_valid_q;

	assign emit_raw  = chan_q[emit_q[CH_SEL_W-1:0]];
	assign pulse_sum = PULSE_BASE + (high_res_q ? {2'b00, emit_raw[VALUE_W-1:1]}
		: {1'b0, emit_raw});
	assign pulse_sat = (pulse_sum > PULSE_MAX) ? PULSE_MAX[PULSE_W-1:0]
		: pulse_sum[PULSE_W-1:0];

	assign sts.emit_last = (({1'b0, emit_q} + (CH_W+1)'(1)) == count);
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				emit_q <= '0;
			end else if (cmd.emit_load) begin
				emit_q <= emit_q + CH_W'(1);
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			channel_index <= emit_q;
			pulse_value   <= pulse_sat;
			last_channel  <= sts.emit_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/rc_serial_frame_decoder.sv -----
// top level of the serial receiver frame decoder
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------------------
//   cfg      | in  | cfg_write            | cfg_index, cfg_data
//   byte in  | in  | in_valid / in_stall  | rx_byte, gap_us, period_index
//   channel  | out | out_valid / out_stall| channel_index, pulse_value, last_channel
//
// a byte that does not complete a frame is taken without raising in_stall
// the completing byte starts the ram read-out of all FRAME_BYTES bytes and a drain state,
// then one channel item per cycle while the output is not stalled (12 or 7 channels):
// in_stall is high until the last channel item is loaded
// a stalled output holds the report; the next item loads as the current one is taken
// reset clears the controller, byte position, fade history and channel store; the
// frame ram has no reset and is always written before it is read
module rc_serial_frame_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_write,
	input  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcfd_pkg::CFG_W-1:0]     cfg_data,
	// received bytes
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rcfd_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [rcfd_pkg::TIME_W-1:0]    gap_us,
	input  logic [rcfd_pkg::TIME_W-1:0]    period_index,
	// channel report
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rcfd_pkg::CH_W-1:0]      channel_index,
	output logic [rcfd_pkg::PULSE_W-1:0]   pulse_value,
	output logic                          last_channel
);

	import rcfd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: idle intake, ram read-out, drain state, report
	rcfd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// storage, strength, decode and the output register
	rcfd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.gap_us       (gap_us),
		.period_index (period_index),
		.cmd          (cmd),
		.sts          (sts),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.channel_index(channel_index),
		.pulse_value  (pulse_value),
		.last_channel (last_channel)
	);

endmodule

// ----- hw/rtl/rcfd_checker.sv -----
// port-level checks on the frame decoder, bound to the top level
`include "assert_macros.svh"

module rcfd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [rcfd_pkg::CH_W-1:0]    channel_index,
	input logic [rcfd_pkg::PULSE_W-1:0] pulse_value,
	input logic                        last_channel
);

	import rcfd_pkg::*;

	logic [CH_W+PULSE_W:0] out_payload;

	assign out_payload = {channel_index, pulse_value, last_channel};

	// a stalled item stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// a stalled item keeps its payload
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_payload))

	// reported channels stay inside the store
	`ASSERT_IMPLY(a_index_range, clk, arst_n, out_valid, channel_index < CH_W'(MAX_CHANNELS))

	// intake stays closed while a report is still being emitted
	`ASSERT_IMPLY(a_busy_report, clk, arst_n, out_valid && !last_channel, in_stall)

endmodule

bind rc_serial_frame_decoder rcfd_checker u_rcfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.channel_index(channel_index),
	.pulse_value  (pulse_value),
	.last_channel (last_channel)
);

// ----- tb/rc_serial_frame_decoder_tb.sv -----
// self-checking testbench for the serial receiver frame decoder
`timescale 1ns / 100ps

module rc_serial_frame_decoder_tb;
	import rcfd_pkg::*;

	// one received byte item and one channel report item
	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic [TIME_W-1:0] gap;
		logic [TIME_W-1:0] period;
	} rx_item_t;

	typedef struct packed {
		logic [CH_W-1:0]    ch;
		logic [PULSE_W-1:0] pulse;
		logic               last;
	} chan_report_t;

	localparam int TAIL_CYCLES = 60;    // room after a drain for a frame still being read out
	localparam int MAX_SHOWN   = 10;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HIGH_RES;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic [TIME_W-1:0]    gap_us = '0;
	logic [TIME_W-1:0]    period_index = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CH_W-1:0]      channel_index;
	logic [PULSE_W-1:0]   pulse_value;
	logic                 last_channel;

	rc_serial_frame_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.gap_us       (gap_us),
		.period_index (period_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.channel_index(channel_index),
		.pulse_value  (pulse_value),
		.last_channel (last_channel)
	);

	// bytes waiting to be sent and reports waiting to arrive
	rx_item_t     pending_bytes[$];
	chan_report_t expected_reports[$];

	int  bad_reports = 0;    // mismatches and unexpected reports
	int  queued_count = 0;   // bytes queued so far, steers phase lengths
	logic in_took = 1'b0;    // byte item accepted at the last rising edge
	logic quiet = 1'b0;      // no idling on either side while set

	// decoder model: configuration copy and state
	logic              m_hr;
	logic [CH_W-1:0]   m_slot_cfg;
	logic [TIME_W-1:0] m_gap_limit;
	logic [BYTE_W-1:0] m_frame[FRAME_BYTES];
	int                m_pos;
	logic [VALUE_W-1:0] m_vals[MAX_CHANNELS];
	logic              m_fade_seen;
	logic [TIME_W-1:0] m_prior_period;
	logic [TIME_W-1:0] m_prior_fade;

	// stimulus side view of the configuration, plus running period and fade count
	logic              g_hr = 1'b1;
	int                g_lim = 5000;
	logic [TIME_W-1:0] g_period = '0;
	logic [TIME_W-1:0] g_fade = '0;

	// clock, 20 ns period
	initial begin
		forever #10 clk = ~clk;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	task reset_model();
		m_hr = 1'b1;
		m_slot_cfg = '0;
		m_gap_limit = GAP_LIMIT_RST;
		m_pos = 0;
		m_fade_seen = 1'b0;
		m_prior_period = '0;
		m_prior_fade = '0;
		for (int i = 0; i < MAX_CHANNELS; i++) m_vals[i] = '0;
	endtask

	// advance the model by one accepted byte and queue the reports it causes
	task predict_byte(input rx_item_t it);
		int unsigned count, slot, shift, mask, full, drop, v, pulse, hi, ch;
		logic [TIME_W-1:0] fade, delta, step;
		chan_report_t rep;
		// long gap restarts framing
		if (it.gap > m_gap_limit) m_pos = 0;
		// bytes past a full frame are dropped until the next restart
		if (m_pos < FRAME_BYTES) begin
			m_frame[m_pos] = it.b;
			m_pos++;
			if (m_pos == FRAME_BYTES) begin
				count = m_hr ? MAX_CHANNELS : LOW_COUNT;
				// a slot outside the active channels disables strength reporting
				slot = (m_slot_cfg < count) ? m_slot_cfg : 0;
				// strength from fade count, first frame only records history
				fade = {m_frame[0], m_frame[1]};
				if (!m_fade_seen) begin
					m_fade_seen = 1'b1;
					m_prior_fade = fade;
					m_prior_period = it.period;
				end else if (m_prior_period != it.period) begin
					step = it.period - m_prior_period;
					if (step == 16'd1 && slot != 0) begin
						full = m_hr ? 2048 : 1024;
						delta = fade - m_prior_fade;
						drop = delta * full / 20;
						// clamp at zero rather than wrap
						m_vals[slot] = (drop >= full) ? '0 : VALUE_W'(full - drop);
					end
					m_prior_fade = fade;
					m_prior_period = it.period;
				end
				// channel words; unknown ids and the protected strength slot are skipped
				shift = m_hr ? 3 : 2;
				mask = m_hr ? 32'h07 : 32'h03;
				for (int b = 3; b < FRAME_BYTES; b += 2) begin
					hi = m_frame[b - 1];
					ch = (hi >> shift) & 32'h0F;
					if (ch < count && (slot == 0 || ch != slot))
						m_vals[ch] = VALUE_W'(((hi & mask) << 8) + m_frame[b]);
				end
				// report every active channel, pulses saturate at 2047 after a mode switch
				for (int c = 0; c < count; c++) begin
					v = m_vals[c];
					pulse = 988 + (m_hr ? (v >> 1) : v);
					if (pulse > 2047) pulse = 2047;
					rep.ch = CH_W'(c);
					rep.pulse = PULSE_W'(pulse);
					rep.last = (c + 1 == count);
					expected_reports.push_back(rep);
				end
			end
		end
	endtask

	// byte driver: changes on the falling edge, holds a stalled item
	always @(negedge clk) begin : drive_bytes
		rx_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (pending_bytes.size() > 0 && (quiet || $urandom_range(0, 99) >= 28)) begin
				nxt = pending_bytes.pop_front();
				in_valid <= 1'b1;
				rx_byte <= nxt.b;
				gap_us <= nxt.gap;
				period_index <= nxt.period;
			end else begin
				in_valid <= 1'b0;
			end
		end
		// receiver back-pressure on the report channel
		out_stall <= !quiet && ($urandom_range(0, 99) < 28);
	end

	// monitor: config writes and accepted bytes feed the model, reports are checked
	always @(posedge clk) begin : watch_ports
		chan_report_t want;
		in_took <= in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					REG_HIGH_RES: begin
						m_hr = cfg_data[0];
					end
					REG_STRENGTH_CH: begin
						m_slot_cfg = cfg_data[CH_W-1:0];
					end
					REG_GAP_LIMIT: begin
						m_gap_limit = cfg_data[TIME_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall)
				predict_byte({rx_byte, gap_us, period_index});
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					bad_reports++;
					if (bad_reports <= MAX_SHOWN)
						$display("unexpected report: ch %0d pulse %0d last %0d",
							channel_index, pulse_value, last_channel);
				end else begin
					want = expected_reports.pop_front();
					if (channel_index !== want.ch || pulse_value !== want.pulse
							|| last_channel !== want.last) begin
						bad_reports++;
						if (bad_reports <= MAX_SHOWN)
							$display({"report mismatch: expected ch %0d pulse %0d ",
								"last %0d, got ch %0d pulse %0d last %0d"},
								want.ch, want.pulse, want.last,
								channel_index, pulse_value, last_channel);
					end
				end
			end
		end
	end

	task queue_byte(input logic [BYTE_W-1:0] b, input int gap, input logic [TIME_W-1:0] period);
		rx_item_t it;
		it.b = b;
		it.gap = TIME_W'(gap);
		it.period = period;
		pending_bytes.push_back(it);
		queued_count++;
	endtask

	// gap inside a frame, never above the limit
	function automatic int inner_gap();
		int r;
		r = $urandom_range(0, 99);
		if (g_lim == 0) return 0;
		if (r < 10) return g_lim;
		return $urandom_range(0, (g_lim < 200) ? g_lim : 200);
	endfunction

	// gap that forces a restart, or any gap when no restart is possible
	function automatic int restart_gap();
		if (g_lim >= 65535) return $urandom_range(0, 65535);
		return $urandom_range(g_lim + 1, 65535);
	endfunction

	task queue_noise(input int n);
		for (int i = 0; i < n; i++)
			queue_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 65535),
				TIME_W'($urandom_range(0, 65535)));
	endtask

	// one well-formed frame with random content, now and then broken or followed by junk
	task queue_frame();
		int r, count, ch;
		logic [BYTE_W-1:0] hi, lo;
		count = g_hr ? MAX_CHANNELS : LOW_COUNT;
		// mostly consecutive periods so strength updates happen
		r = $urandom_range(0, 99);
		if (r < 70) g_period = g_period + 16'd1;
		else if (r >= 85) g_period = TIME_W'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		if (r < 60) g_fade = g_fade + TIME_W'($urandom_range(0, 19));
		else if (r < 80) g_fade = g_fade + TIME_W'($urandom_range(20, 40));
		else if (r >= 90) g_fade = TIME_W'($urandom_range(0, 65535));
		queue_byte(g_fade[15:8], restart_gap(), g_period);
		queue_byte(g_fade[7:0], inner_gap(), g_period);
		for (int p = 0; p < 7; p++) begin
			hi = BYTE_W'($urandom_range(0, 255));
			lo = BYTE_W'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < 85) begin
				ch = $urandom_range(0, count - 1);
				if (g_hr) hi[6:3] = ch[3:0];
				else hi[5:2] = ch[3:0];
			end
			// value extremes
			r = $urandom_range(0, 99);
			if (r < 10) begin
				hi[2:0] = g_hr ? 3'b111 : {hi[2], 2'b11};
				lo = 8'hFF;
			end else if (r < 20) begin
				hi[2:0] = g_hr ? 3'b000 : {hi[2], 2'b00};
				lo = 8'h00;
			end
			// broken frame: a long gap in the middle restarts framing here
			if (g_lim < 65535 && $urandom_range(0, 99) < 3)
				queue_byte(BYTE_W'($urandom_range(0, 255)), restart_gap(), g_period);
			queue_byte(hi, inner_gap(), g_period);
			queue_byte(lo, inner_gap(), g_period);
		end
		// trailing bytes with short gaps are dropped by the block
		if ($urandom_range(0, 99) < 15) begin
			r = $urandom_range(1, 3);
			for (int i = 0; i < r; i++)
				queue_byte(BYTE_W'($urandom_range(0, 255)), inner_gap(),
					TIME_W'($urandom_range(0, 65535)));
		end
	endtask

	task run_frames(input int n);
		int start;
		start = queued_count;
		while (queued_count - start < n) begin
			if ($urandom_range(0, 99) < 88) queue_frame();
			else queue_noise($urandom_range(1, 4));
		end
	endtask

	// sender stops until every queued byte is taken and every report has come
	task drain();
		while (pending_bytes.size() != 0 || in_valid || expected_reports.size() != 0)
			@(negedge clk);
	endtask

	// idle point: drained, then room for a frame still being read out
	task settle();
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task set_config(input logic hr, input int slot, input int lim);
		write_reg(REG_HIGH_RES, hr);
		write_reg(REG_STRENGTH_CH, slot);
		write_reg(REG_GAP_LIMIT, lim);
		g_hr = hr;
		g_lim = lim;
	endtask

	initial begin
		reset_model();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frame under reset settings: fade history recorded, value extremes,
		// unknown channel ids 15 and 12, ignored bits above the id field
		queue_byte(8'h00, 0, 16'h0000);
		queue_byte(8'h00, 0, 16'h0000);
		queue_byte(8'h07, 1, 16'h0000);    // ch 0, max value
		queue_byte(8'hFF, 1, 16'h0000);
		queue_byte(8'h58, 5000, 16'h0000); // ch 11, zero, gap at the limit
		queue_byte(8'h00, 0, 16'h0000);
		queue_byte(8'hFF, 0, 16'h0000);    // id 15, ignored
		queue_byte(8'hFF, 0, 16'h0000);
		queue_byte(8'h0C, 0, 16'h0000);    // ch 1
		queue_byte(8'h00, 0, 16'h0000);
		queue_byte(8'h60, 0, 16'h0000);    // id 12, ignored
		queue_byte(8'h55, 0, 16'h0000);
		queue_byte(8'h2B, 0, 16'h0000);    // ch 5
		queue_byte(8'hAA, 0, 16'h0000);
		queue_byte(8'h95, 0, 16'h0000);    // ch 2 with top bit set
		queue_byte(8'h80, 0, 16'hFFFF);
		// full frame: short gaps are dropped, gap at the limit too
		queue_byte(8'h12, 10, 16'hFFFF);
		queue_byte(8'h34, 5000, 16'hFFFF);
		// one above the limit restarts framing, then a partial frame
		queue_byte(8'h00, 5001, 16'h0001);
		queue_byte(8'h03, 65535, 16'h0001);
		queue_byte(8'hA5, 0, 16'h0001);
		queue_byte(8'h5A, 0, 16'h0001);
		settle();

		// high resolution with strength in slot 5; sender pauses halfway
		set_config(1'b1, 5, 5000);
		run_frames(30);
		drain();
		run_frames(30);
		settle();

		// low resolution with stale high-resolution values, zero gap limit
		set_config(1'b0, 3, 0);
		run_frames(40);
		settle();

		// slot 9 is outside the seven low-resolution channels, so no strength
		set_config(1'b0, 9, 1000);
		run_frames(40);
		settle();

		// largest gap limit: framing never restarts, top slot
		set_config(1'b1, 11, 65535);
		queue_noise(8);
		run_frames(15);
		settle();

		// strength off, no idling on either side
		set_config(1'b1, 0, 300);
		quiet = 1'b1;
		run_frames(45);
		settle();
		quiet = 1'b0;

		// top low-resolution slot
		set_config(1'b0, 6, 65534);
		run_frames(30);
		settle();

		set_config(1'b1, 11, 2500);
		run_frames(30);
		settle();

		if (bad_reports == 0 && expected_reports.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/rcfd_pkg.sv
hw/rtl/rcfd_ram.sv
hw/rtl/rcfd_ctrl.sv
hw/rtl/rcfd_dp.sv
hw/rtl/rc_serial_frame_decoder.sv
hw/rtl/rcfd_checker.sv
tb/rc_serial_frame_decoder_tb.sv
